// ===== rtl/cgns_pkg.sv =====
// shared constants, register indexes and the result record for the grid smoothing block
// no dependencies; used by cell_grid_neighbor_smoothing, cgns_out_fifo and the testbench
package cgns_pkg;

    // grid size limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // configuration register widths
    localparam int SIZE_W     = 9;
    localparam int LIMIT_W    = 4;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic [SIZE_W-1:0]  FRAME_WIDTH_RST  = 9'd180;
    localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_RST = 9'd120;
    localparam logic [LIMIT_W-1:0] WATER_LIMIT_RST  = 4'd4;
    localparam logic [SIZE_W-1:0]  MIN_SIZE         = 9'd3;

    // line memory entry: bit 0 row two above, bit 1 row directly above
    localparam int LINE_W = 2;

    // neighbor count width (eight neighbors)
    localparam int NBR_N  = 8;
    localparam int WATER_W = 4;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // output coordinate width
    localparam int COORD_W = 8;

    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               cell_out;
        logic               frame_last;
    } result_t;

endpackage

// ===== rtl/cgns_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; read returns the old contents on a same-address write
module cgns_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // storage write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/cgns_out_fifo.sv =====
// small result queue between the smoothing stage and the output channel
// depends on cgns_pkg for the result record and queue sizing
module cgns_out_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  cgns_pkg::result_t                   push_data,
    input  logic                                pop_ready,
    output logic                                head_valid,
    output cgns_pkg::result_t                   head_data,
    output logic [cgns_pkg::FIFO_CNT_W-1:0]     fill
);

    cgns_pkg::result_t                     entry_reg [cgns_pkg::FIFO_DEPTH];
    logic [cgns_pkg::FIFO_PTR_W-1:0]       wr_ptr_reg;
    logic [cgns_pkg::FIFO_PTR_W-1:0]       rd_ptr_reg;
    logic [cgns_pkg::FIFO_CNT_W-1:0]       count_reg;
    logic [cgns_pkg::FIFO_CNT_W-1:0]       count_next;
    logic                                  pop;

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign fill       = count_reg;
    assign pop        = head_valid & pop_ready;

    // occupancy update
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/cell_grid_neighbor_smoothing.sv =====
// top level of the land/water grid smoothing block: position counters, line memory access,
// 3x3 window and neighbor count; depends on cgns_pkg, cgns_ram and cgns_out_fifo
//
// Takes one grid cell per request in raster order and, for every interior cell, reports the
// smoothed value with its row and column once the cell below-right of it has arrived. Border
// cells produce no result. The block accepts one cell every clock cycle while s_ready is high;
// that figure is set by the single line memory, which is read once and written once per cell
// (upper and middle rows share one entry per column). A result passes from the stage 1
// registers into a four-entry result queue before it is offered on the output; the queue
// absorbs up to four results while the output side stalls, after which s_ready stays low
// until the queue has room again. The line memory needs no clearing pass after reset:
// per-column valid bits make unwritten columns read as water.
module cell_grid_neighbor_smoothing (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [cgns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cgns_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // cell input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cell_in,
    input  logic                                s_frame_start,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cgns_pkg::COORD_W-1:0]        m_out_row,
    output logic [cgns_pkg::COORD_W-1:0]        m_out_col,
    output logic                                m_cell_out,
    output logic                                m_frame_last
);

    // configuration registers
    logic [cgns_pkg::SIZE_W-1:0]     frame_width_reg;
    logic [cgns_pkg::SIZE_W-1:0]     frame_height_reg;
    logic [cgns_pkg::LIMIT_W-1:0]    water_limit_reg;
    logic [cgns_pkg::SIZE_W-1:0]     width_eff;
    logic [cgns_pkg::SIZE_W-1:0]     height_eff;

    // position counters
    logic [cgns_pkg::COL_W-1:0]      col_count_reg;
    logic [cgns_pkg::COL_W-1:0]      col_count_next;
    logic [cgns_pkg::ROW_W-1:0]      row_count_reg;
    logic [cgns_pkg::ROW_W-1:0]      row_count_next;
    logic [cgns_pkg::COL_W-1:0]      cur_col;
    logic [cgns_pkg::ROW_W-1:0]      cur_row;
    logic [cgns_pkg::SIZE_W-1:0]     col_ext;
    logic [cgns_pkg::SIZE_W-1:0]     row_ext;
    logic [cgns_pkg::SIZE_W-1:0]     col_inc;
    logic [cgns_pkg::SIZE_W-1:0]     row_inc;
    logic                            s_accept;
    logic                            cur_emit;
    logic                            cur_last;

    // stage 1 registers
    logic                            s1_valid_reg;
    logic                            s1_cell_reg;
    logic [cgns_pkg::COL_W-1:0]      s1_addr_reg;
    logic                            s1_emit_reg;
    logic                            s1_last_reg;
    logic [cgns_pkg::COORD_W-1:0]    s1_row_reg;
    logic [cgns_pkg::COORD_W-1:0]    s1_col_reg;

    // line memory and forwarding
    logic [cgns_pkg::MAX_WIDTH-1:0]  line_vld_reg;
    logic                            rd_vld_reg;
    logic                            byp_hit_reg;
    logic [cgns_pkg::LINE_W-1:0]     byp_data_reg;
    logic [cgns_pkg::LINE_W-1:0]     ram_rd_data;
    logic [cgns_pkg::LINE_W-1:0]     line_old;
    logic [cgns_pkg::LINE_W-1:0]     line_wr_data;

    // window and neighbor count
    logic [5:0]                      window_cols_reg;
    logic [2:0]                      col_now;
    logic [cgns_pkg::NBR_N-1:0]      nbr_bits;
    logic [cgns_pkg::WATER_W-1:0]    water_cnt;
    logic                            cell_new;

    // result queue
    logic                            fifo_push;
    cgns_pkg::result_t               fifo_in;
    cgns_pkg::result_t               fifo_head;
    logic [cgns_pkg::FIFO_CNT_W-1:0] fifo_fill;
    logic [cgns_pkg::FIFO_CNT_W:0]   fifo_need;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= cgns_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= cgns_pkg::FRAME_HEIGHT_RST;
            water_limit_reg  <= cgns_pkg::WATER_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cgns_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wr_data[cgns_pkg::SIZE_W-1:0];
                end
                cgns_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wr_data[cgns_pkg::SIZE_W-1:0];
                end
                cgns_pkg::REG_WATER_LIMIT: begin
                    water_limit_reg <= cfg_wr_data[cgns_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp grid size to the supported range
    always_comb begin
        if (frame_width_reg < cgns_pkg::MIN_SIZE) begin
            width_eff = cgns_pkg::MIN_SIZE;
        end else if (frame_width_reg > cgns_pkg::SIZE_W'(cgns_pkg::MAX_WIDTH)) begin
            width_eff = cgns_pkg::SIZE_W'(cgns_pkg::MAX_WIDTH);
        end else begin
            width_eff = frame_width_reg;
        end
        if (frame_height_reg < cgns_pkg::MIN_SIZE) begin
            height_eff = cgns_pkg::MIN_SIZE;
        end else if (frame_height_reg > cgns_pkg::SIZE_W'(cgns_pkg::MAX_HEIGHT)) begin
            height_eff = cgns_pkg::SIZE_W'(cgns_pkg::MAX_HEIGHT);
        end else begin
            height_eff = frame_height_reg;
        end
    end

    // position of the incoming cell and whether it completes an interior neighborhood
    assign s_accept = s_valid & s_ready;
    assign cur_col  = s_frame_start ? '0 : col_count_reg;
    assign cur_row  = s_frame_start ? '0 : row_count_reg;
    assign col_ext  = cgns_pkg::SIZE_W'(cur_col);
    assign row_ext  = cgns_pkg::SIZE_W'(cur_row);
    assign col_inc  = col_ext + 1'b1;
    assign row_inc  = row_ext + 1'b1;
    assign cur_emit = (row_ext >= 9'd2) && (col_ext >= 9'd2) &&
                      (row_ext < height_eff) && (col_ext < width_eff);
    assign cur_last = (row_ext == height_eff - 1'b1) && (col_ext == width_eff - 1'b1);

    // raster advance with wrap at row and grid end
    always_comb begin
        if (col_inc >= width_eff) begin
            col_count_next = '0;
            if (row_inc >= height_eff) begin
                row_count_next = '0;
            end else begin
                row_count_next = row_inc[cgns_pkg::ROW_W-1:0];
            end
        end else begin
            col_count_next = col_inc[cgns_pkg::COL_W-1:0];
            row_count_next = cur_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cell_reg <= s_cell_in;
            s1_addr_reg <= cur_col;
            s1_emit_reg <= cur_emit;
            s1_last_reg <= cur_last;
            s1_row_reg  <= cgns_pkg::COORD_W'(row_ext - 1'b1);
            s1_col_reg  <= cgns_pkg::COORD_W'(col_ext - 1'b1);
        end
    end

    // line memory: one entry per column holds the two previous rows
    cgns_ram #(
        .WIDTH (cgns_pkg::LINE_W),
        .DEPTH (cgns_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (line_wr_data),
        .rd_en   (s_accept),
        .rd_addr (cur_col),
        .rd_data (ram_rd_data)
    );

    // per-column written flags so unwritten columns read as water
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_vld_reg <= '0;
        end else if (s1_valid_reg) begin
            line_vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // forward a write that lands on the same edge as the read of the same column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
        end else if (s_accept) begin
            byp_hit_reg <= s1_valid_reg && (cur_col == s1_addr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_vld_reg   <= line_vld_reg[cur_col];
            byp_data_reg <= line_wr_data;
        end
    end

    // read-modify-write of the column entry
    always_comb begin
        if (byp_hit_reg) begin
            line_old = byp_data_reg;
        end else if (rd_vld_reg) begin
            line_old = ram_rd_data;
        end else begin
            line_old = '0;
        end
    end

    assign line_wr_data = {s1_cell_reg, line_old[1]};
    assign col_now      = {s1_cell_reg, line_old[1], line_old[0]};

    // eight neighbors: column c-2, column c, column c-1 without its center
    assign nbr_bits = {window_cols_reg[5:3], col_now, window_cols_reg[2], window_cols_reg[0]};

    always_comb begin
        water_cnt = '0;
        for (int i = 0; i < cgns_pkg::NBR_N; i++) begin
            water_cnt = water_cnt + cgns_pkg::WATER_W'(!nbr_bits[i]);
        end
    end

    assign cell_new = (water_cnt > water_limit_reg) ? 1'b0 : 1'b1;

    // window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_cols_reg <= '0;
        end else if (s1_valid_reg) begin
            window_cols_reg <= {window_cols_reg[2:0], col_now};
        end
    end

    // result queue and input flow control
    assign fifo_push           = s1_valid_reg & s1_emit_reg;
    assign fifo_in.out_row     = s1_row_reg;
    assign fifo_in.out_col     = s1_col_reg;
    assign fifo_in.cell_out    = cell_new;
    assign fifo_in.frame_last  = s1_last_reg;

    cgns_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fifo_push),
        .push_data  (fifo_in),
        .pop_ready  (m_ready),
        .head_valid (m_valid),
        .head_data  (fifo_head),
        .fill       (fifo_fill)
    );

    // room for the queued results, the one in stage 1 and the one about to be taken
    assign fifo_need = {1'b0, fifo_fill} + (cgns_pkg::FIFO_CNT_W + 1)'(fifo_push);
    assign s_ready   = (fifo_need <= (cgns_pkg::FIFO_CNT_W + 1)'(cgns_pkg::FIFO_DEPTH - 1));

    assign m_out_row    = fifo_head.out_row;
    assign m_out_col    = fifo_head.out_col;
    assign m_cell_out   = fifo_head.cell_out;
    assign m_frame_last = fifo_head.frame_last;

`ifndef SYNTH
    // queue never takes a result while full and not draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_push && (fifo_fill == cgns_pkg::FIFO_CNT_W'(cgns_pkg::FIFO_DEPTH)) &&
          !(m_valid && m_ready)))
        else $error("result queue overflow");

    // a frame start request restarts the line memory access at column zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_frame_start) |=> (s1_valid_reg && (s1_addr_reg == '0)))
        else $error("frame start did not restart at column zero");

    // a request whose column matches the pending write is always forwarded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s1_valid_reg && (cur_col == s1_addr_reg)) |=> byp_hit_reg)
        else $error("same-column write not forwarded");
`endif

endmodule

// ===== dv/cgns_tb_pkg.sv =====
// scoreboard for the grid smoothing testbench: cell-by-cell prediction of the smoothed
// results and in-order checking of what comes out; depends on cgns_pkg
package cgns_tb_pkg;
    import cgns_pkg::*;

    // grid size as the block uses it
    function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    class smoothing_scoreboard;
        // register copies
        logic [SIZE_W-1:0]  width_reg;
        logic [SIZE_W-1:0]  height_reg;
        logic [LIMIT_W-1:0] limit_reg;

        // line memories, window and raster position
        bit       upper_row [MAX_WIDTH];
        bit       middle_row[MAX_WIDTH];
        bit [5:0] window;
        int       col;
        int       row;

        result_t  smoothed_cells[$];
        int       fail_count;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            limit_reg  = WATER_LIMIT_RST;
            foreach (upper_row[i]) begin
                upper_row[i]  = 1'b0;
                middle_row[i] = 1'b0;
            end
            window     = '0;
            col        = 0;
            row        = 0;
            fail_count = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = val[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg = val[SIZE_W-1:0];
                REG_WATER_LIMIT:  limit_reg  = val[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return smoothed_cells.size();
        endfunction

        // one line per mismatch
        function void report(input string msg);
            fail_count++;
            $display("mismatch: %s", msg);
        endfunction

        // accepted cell request: advance the window and queue the smoothed cell if interior
        function void note_cell(input bit cell_bit, input bit frame_start);
            int       w;
            int       h;
            int       water;
            bit [2:0] col_now;
            bit [7:0] nbr;
            result_t  res;
            w = clamp_size(width_reg, MAX_WIDTH);
            h = clamp_size(height_reg, MAX_HEIGHT);
            if (frame_start) begin
                col = 0;
                row = 0;
            end
            col_now = {cell_bit, middle_row[col], upper_row[col]};
            if (row >= 2 && col >= 2 && row < h && col < w) begin
                // column c-2 whole, column c whole, column c-1 without the center
                nbr   = {window[5:3], col_now, window[2], window[0]};
                water = 0;
                for (int i = 0; i < NBR_N; i++) begin
                    if (!nbr[i]) water++;
                end
                res.out_row    = COORD_W'(row - 1);
                res.out_col    = COORD_W'(col - 1);
                res.cell_out   = (water > limit_reg) ? 1'b0 : 1'b1;
                res.frame_last = (row == h - 1 && col == w - 1);
                smoothed_cells.push_back(res);
            end
            upper_row[col]  = middle_row[col];
            middle_row[col] = cell_bit;
            window          = {window[2:0], col_now};
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void compare_field(input string name, input logic [7:0] got,
                                    input logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endfunction

        // accepted result request against the oldest smoothed cell
        function void check_result(input logic [COORD_W-1:0] out_row,
                                   input logic [COORD_W-1:0] out_col,
                                   input logic cell_out, input logic frame_last);
            result_t want;
            if (smoothed_cells.size() == 0) begin
                report($sformatf("unexpected result row %0d col %0d", out_row, out_col));
                return;
            end
            want = smoothed_cells.pop_front();
            compare_field("out_row", out_row, want.out_row);
            compare_field("out_col", out_col, want.out_col);
            compare_field("cell_out", {7'd0, cell_out}, {7'd0, want.cell_out});
            compare_field("frame_last", {7'd0, frame_last}, {7'd0, want.frame_last});
        endfunction
    endclass

endpackage

// ===== dv/cell_grid_neighbor_smoothing_tb.sv =====
// testbench top for cell_grid_neighbor_smoothing: directed grids, then random grids of
// random sizes under varied idling; depends on cgns_pkg and cgns_tb_pkg
module cell_grid_neighbor_smoothing_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cgns_pkg::*;
    import cgns_tb_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int TARGET_CELLS  = 2000;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_cell_in     = 1'b0;
    logic                  s_frame_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [COORD_W-1:0]    m_out_row;
    logic [COORD_W-1:0]    m_out_col;
    logic                  m_cell_out;
    logic                  m_frame_last;

    smoothing_scoreboard sb;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int cells_sent = 0;

    cell_grid_neighbor_smoothing u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_in     (s_cell_in),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_cell_out    (m_cell_out),
        .m_frame_last  (m_frame_last)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: check accepted requests, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_row, m_out_col, m_cell_out, m_frame_last);
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // one cell request, with random idle cycles ahead of it
    task automatic send_cell(input bit cell_bit, input bit frame_start);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cell_in     <= cell_bit;
        s_frame_start <= frame_start;
        do @(posedge aclk); while (!s_ready);
        sb.note_cell(cell_bit, frame_start);
        cells_sent++;
    endtask

    // raster walk over a grid; num_cells below the area leaves the grid unfinished
    task automatic feed_grid(input int we, input int he, input bit use_fs, input int num_cells,
                             input int density, input bit border_water);
        int  r;
        int  c;
        bit  cell_bit;
        bit  fs;
        for (int i = 0; i < num_cells; i++) begin
            r        = (i / we) % he;
            c        = i % we;
            cell_bit = ($urandom_range(0, 99) < density);
            if (border_water && (r == 0 || c == 0 || r == he - 1 || c == we - 1))
                cell_bit = 1'b0;
            // occasional stray frame start mid-grid
            fs   = (i == 0 && use_fs) || ($urandom_range(0, 299) == 0);
            send_cell(cell_bit, fs);
        end
    endtask

    // drop valid and wait until the block has drained
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                input logic [LIMIT_W-1:0] lim);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_FRAME_WIDTH;
        cfg_wr_data <= w;
        sb.set_reg(REG_FRAME_WIDTH, w);
        @(posedge aclk);
        cfg_index   <= REG_FRAME_HEIGHT;
        cfg_wr_data <= h;
        sb.set_reg(REG_FRAME_HEIGHT, h);
        @(posedge aclk);
        cfg_index   <= REG_WATER_LIMIT;
        cfg_wr_data <= CFG_DATA_W'(lim);
        sb.set_reg(REG_WATER_LIMIT, CFG_DATA_W'(lim));
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly small sizes, sometimes clamped extremes, large only when allowed
    function automatic logic [SIZE_W-1:0] pick_size(input bit big_ok);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return SIZE_W'($urandom_range(0, 3));
        if (big_ok && sel < 12) return SIZE_W'(MAX_WIDTH);
        if (big_ok && sel < 15) return SIZE_W'($urandom_range(257, 511));
        if (big_ok && sel < 18) return SIZE_W'($urandom_range(40, 255));
        return SIZE_W'($urandom_range(3, 14));
    endfunction

    initial begin
        int                 phase;
        int                 we;
        int                 he;
        int                 area;
        int                 grids;
        int                 density;
        logic [SIZE_W-1:0]  w_val;
        logic [SIZE_W-1:0]  h_val;
        logic [LIMIT_W-1:0] lim;

        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: undersized registers clamp to 3x3, all land with zero limit
        write_config(9'd0, 9'd2, 4'd0);
        feed_grid(3, 3, 1'b1, 9, 100, 1'b0);
        settle();
        // large limit: a broken grid, then an all-water grid smooths to land
        write_config(9'd3, 9'd3, 4'd15);
        feed_grid(3, 3, 1'b0, 2, 50, 1'b0);
        feed_grid(3, 3, 1'b1, 9, 0, 1'b0);
        settle();
        // back-to-back grid without frame start, all water stays water
        write_config(9'd3, 9'd3, 4'd7);
        feed_grid(3, 3, 1'b0, 9, 0, 1'b0);
        settle();

        // random phases, idling mode rotates per phase
        phase = 0;
        while (cells_sent < TARGET_CELLS) begin
            w_val = pick_size(1'b1);
            we    = clamp_size(w_val, MAX_WIDTH);
            h_val = pick_size(we < 40);
            he    = clamp_size(h_val, MAX_HEIGHT);
            lim   = LIMIT_W'($urandom_range(0, 15));
            settle();
            write_config(w_val, h_val, lim);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 55; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 55; end
                default: begin idle_pct = 29; stall_pct <= 29; end
            endcase
            area  = we * he;
            grids = (area >= 300) ? 1 : $urandom_range(1, (600 / area > 6) ? 6 : 600 / area);
            for (int g = 0; g < grids; g++) begin
                case ($urandom_range(0, 5))
                    0: density = 0;
                    1: density = 100;
                    default: density = $urandom_range(20, 80);
                endcase
                feed_grid(we, he, (g == 0) ? ($urandom_range(0, 3) != 0) : $urandom_range(0, 1),
                          area, density, $urandom_range(0, 1));
            end
            // leave some grids unfinished so the next size lands mid-grid
            if ($urandom_range(0, 2) == 0)
                feed_grid(we, he, $urandom_range(0, 1), $urandom_range(1, area - 1),
                          $urandom_range(0, 100), 1'b0);
            phase++;
        end

        settle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
